>>> hdl/lidsf_pkg.sv
package lidsf_pkg;

    // Field and datapath widths
    localparam int CW        = 16;   // config, coordinate width
    localparam int DW        = 17;   // offset-corrected coordinate
    localparam int PW        = 33;   // one 16x17 product
    localparam int UW        = 34;   // rotated vector before CORDIC
    localparam int XW        = 36;   // CORDIC x/y, covers the gain of ~1.65
    localparam int ZW        = 34;   // angle, radians x 2^30
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = 3;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);

    // atan(2^-i) x 2^30, truncated
    localparam logic [30:0] ATAN_Q30 [TABLE_LEN] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
        31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
        31'd262143,    31'd131071,    31'd65535,     31'd32767,
        31'd16383,     31'd8191,      31'd4095,      31'd2047,
        31'd1023,      31'd511,       31'd255,       31'd127
    };

    // Register indexes
    localparam logic [IDX_W-1:0] REG_OFFSET_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_YAW_COS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_YAW_SIN      = 3'd3;
    localparam logic [IDX_W-1:0] REG_FRONT_LOW    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FRONT_HIGH   = 3'd5;
    localparam logic [IDX_W-1:0] REG_REAR_LOW     = 3'd6;
    localparam logic [IDX_W-1:0] REG_REAR_HIGH    = 3'd7;

    typedef struct packed {
        logic signed [CW-1:0] offset_x;
        logic signed [CW-1:0] offset_y;
        logic signed [CW-1:0] yaw_cos;
        logic signed [CW-1:0] yaw_sin;
        logic signed [CW-1:0] front_angle_low;
        logic signed [CW-1:0] front_angle_high;
        logic signed [CW-1:0] rear_angle_low;
        logic signed [CW-1:0] rear_angle_high;
    } t_cfg;

    // One item in flight through the CORDIC
    typedef struct packed {
        logic                 mode;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

endpackage

>>> hdl/lidsf_cfg.sv
module lidsf_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lidsf_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [lidsf_pkg::CW-1:0]       i_cfg_data,
    output lidsf_pkg::t_cfg                o_cfg
);
    import lidsf_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x         <= 16'sd0;
            r_cfg.offset_y         <= 16'sd0;
            r_cfg.yaw_cos          <= 16'sd16384;
            r_cfg.yaw_sin          <= 16'sd0;
            r_cfg.front_angle_low  <= -16'sd25736;
            r_cfg.front_angle_high <= 16'sd25736;
            r_cfg.rear_angle_low   <= -16'sd25736;
            r_cfg.rear_angle_high  <= 16'sd25736;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OFFSET_X:   r_cfg.offset_x         <= i_cfg_data;
                REG_OFFSET_Y:   r_cfg.offset_y         <= i_cfg_data;
                REG_YAW_COS:    r_cfg.yaw_cos          <= i_cfg_data;
                REG_YAW_SIN:    r_cfg.yaw_sin          <= i_cfg_data;
                REG_FRONT_LOW:  r_cfg.front_angle_low  <= i_cfg_data;
                REG_FRONT_HIGH: r_cfg.front_angle_high <= i_cfg_data;
                REG_REAR_LOW:   r_cfg.rear_angle_low   <= i_cfg_data;
                REG_REAR_HIGH:  r_cfg.rear_angle_high  <= i_cfg_data;
                default:        r_cfg                  <= r_cfg;
            endcase
        end
    end

endmodule

>>> hdl/lidsf_front.sv
module lidsf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lidsf_pkg::t_cfg             i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic signed [lidsf_pkg::CW-1:0] i_point_x,
    input  logic signed [lidsf_pkg::CW-1:0] i_point_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output lidsf_pkg::t_cordic          o_data
);
    import lidsf_pkg::*;

    // stage 1: offset subtract
    logic                 r_vld1, r_mode1;
    logic signed [CW-1:0] r_px1, r_py1;
    logic signed [DW-1:0] r_dx1, r_dy1;
    // stage 2: products
    logic                 r_vld2, r_mode2;
    logic signed [CW-1:0] r_px2, r_py2;
    logic signed [PW-1:0] r_cdx2, r_sdy2, r_cdy2, r_sdx2;
    // stage 3: rotated vector
    logic                 r_vld3, r_mode3;
    logic signed [CW-1:0] r_px3, r_py3;
    logic signed [UW-1:0] r_u3, r_v3;
    // stage 4: quadrant pre-rotation
    logic                 r_vld4;
    t_cordic              r_data4, n_data4;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic signed [PW-1:0] w_c, w_s, w_dx, w_dy;
    logic signed [XW-1:0] w_u, w_v;

    assign w_rdy4  = !r_vld4 || i_ready;
    assign w_rdy3  = !r_vld3 || w_rdy4;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld4;
    assign o_data  = r_data4;

    assign w_c  = PW'(i_cfg.yaw_cos);
    assign w_s  = PW'(i_cfg.yaw_sin);
    assign w_dx = PW'(r_dx1);
    assign w_dy = PW'(r_dy1);

    assign w_u = XW'(r_u3);
    assign w_v = XW'(r_v3);

    always_comb begin
        n_data4.mode = r_mode3;
        n_data4.px   = r_px3;
        n_data4.py   = r_py3;
        n_data4.x    = w_u;
        n_data4.y    = w_v;
        n_data4.z    = '0;
        if (w_u < 0) begin
            if (w_v >= 0) begin
                n_data4.x = w_v;
                n_data4.y = -w_u;
                n_data4.z = HALF_PI_Q30;
            end else begin
                n_data4.x = -w_v;
                n_data4.y = w_u;
                n_data4.z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
            if (w_rdy3) r_vld3 <= r_vld2;
            if (w_rdy4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_mode1 <= i_mode;
            r_px1   <= i_point_x;
            r_py1   <= i_point_y;
            r_dx1   <= DW'(i_point_x) - DW'(i_cfg.offset_x);
            r_dy1   <= DW'(i_point_y) - DW'(i_cfg.offset_y);
        end
        if (w_rdy2 && r_vld1) begin
            r_mode2 <= r_mode1;
            r_px2   <= r_px1;
            r_py2   <= r_py1;
            r_cdx2  <= w_c * w_dx;
            r_sdy2  <= w_s * w_dy;
            r_cdy2  <= w_c * w_dy;
            r_sdx2  <= w_s * w_dx;
        end
        if (w_rdy3 && r_vld2) begin
            r_mode3 <= r_mode2;
            r_px3   <= r_px2;
            r_py3   <= r_py2;
            if (r_mode2) begin
                // second-sensor point: raw vector scaled to match the rotation gain
                r_u3 <= UW'(r_px2) <<< 14;
                r_v3 <= UW'(r_py2) <<< 14;
            end else begin
                r_u3 <= UW'(r_cdx2) + UW'(r_sdy2);
                r_v3 <= UW'(r_cdy2) - UW'(r_sdx2);
            end
        end
        if (w_rdy4 && r_vld3) begin
            r_data4 <= n_data4;
        end
    end

endmodule

>>> hdl/lidsf_cordic_stage.sv
module lidsf_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lidsf_pkg::t_cordic i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output lidsf_pkg::t_cordic o_data
);
    import lidsf_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = {{(ZW-31){1'b0}}, ATAN_Q30[SHIFT]};

    logic                 r_vld;
    t_cordic              r_data, n_data;
    logic signed [XW-1:0] w_xs, w_ys;
    logic                 w_pos, w_neg;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    // floor shifts
    assign w_xs  = i_data.x >>> SHIFT;
    assign w_ys  = i_data.y >>> SHIFT;
    assign w_neg = i_data.y[XW-1];
    assign w_pos = !i_data.y[XW-1] && (i_data.y != '0);

    always_comb begin
        n_data = i_data;
        if (w_pos) begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + ATAN;
        end else if (w_neg) begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

>>> hdl/lidsf_window.sv
module lidsf_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lidsf_pkg::t_cfg                 i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  lidsf_pkg::t_cordic              i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_out_mode,
    output logic signed [lidsf_pkg::CW-1:0] o_out_x,
    output logic signed [lidsf_pkg::CW-1:0] o_out_y
);
    import lidsf_pkg::*;

    logic                 r_vld, r_mode;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [CW-1:0] w_lo16, w_hi16;
    logic signed [ZW-1:0] w_lo, w_hi;
    logic                 w_keep;

    // mode 0 checks the rear window, mode 1 the front one
    assign w_lo16 = i_data.mode ? i_cfg.front_angle_low  : i_cfg.rear_angle_low;
    assign w_hi16 = i_data.mode ? i_cfg.front_angle_high : i_cfg.rear_angle_high;
    // Q13 bounds to Q30
    assign w_lo   = {w_lo16[CW-1], w_lo16, 17'b0};
    assign w_hi   = {w_hi16[CW-1], w_hi16, 17'b0};
    assign w_keep = (i_data.z >= w_lo) && (i_data.z <= w_hi);

    assign o_ready    = !r_vld || i_ready;
    assign o_valid    = r_vld;
    assign o_out_mode = r_mode;
    assign o_out_x    = r_x;
    assign o_out_y    = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && w_keep) begin
            r_mode <= i_data.mode;
            r_x    <= i_data.px;
            r_y    <= i_data.py;
        end
    end

endmodule

>>> hdl/lidar_overlap_sector_filter_top.sv
// Lidar overlap sector filter.
// Input channel (i_valid/o_ready): one 2D point per item with i_mode. Mode 0
// points are shifted by the configured offset, rotated by minus yaw and
// their bearing is checked against the rear window; mode 1 points have their
// raw bearing checked against the front window. Bounds are inclusive.
// Output channel (o_valid/i_ready): kept points, unchanged, in input order.
// Dropped points leave nothing behind.
// Config channel (i_cfg_valid/o_cfg_ready): register index and 16-bit data,
// always ready; write only while no point is in flight.
// Throughput: one point per cycle while the output is not stalled. From
// acceptance to o_valid a point passes four front stages (offset, multiply,
// sum, quadrant fold), one stage per CORDIC iteration (CORDIC_STAGES capped
// at 24), and the output register.
// A stall at the output holds that register; every pipeline stage has its
// own valid bit and ready, so bubbles collapse and nothing is lost or
// duplicated. o_ready falls only once the whole pipeline is full.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults: no offset, zero yaw, both windows +/-pi.
module lidar_overlap_sector_filter_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lidsf_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [lidsf_pkg::CW-1:0]        i_cfg_data,
    // points in
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_mode,
    input  logic signed [lidsf_pkg::CW-1:0] i_point_x,
    input  logic signed [lidsf_pkg::CW-1:0] i_point_y,
    // kept points out
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_out_mode,
    output logic signed [lidsf_pkg::CW-1:0] o_out_x,
    output logic signed [lidsf_pkg::CW-1:0] o_out_y
);
    import lidsf_pkg::*;

    // iterations beyond the atan table add nothing
    localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    t_cfg    w_cfg;
    t_cordic w_cd  [NSTG+1];
    logic    w_vld [NSTG+1];
    logic    w_rdy [NSTG+1];

    lidsf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // offset, rotation and quadrant fold into the CORDIC start vector
    lidsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_mode    (i_mode),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .o_valid   (w_vld[0]),
        .i_ready   (w_rdy[0]),
        .o_data    (w_cd[0])
    );

    // vectoring CORDIC, one iteration per register stage
    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        lidsf_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    // bearing test and output register; rejected items are dropped here
    lidsf_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_vld[NSTG]),
        .o_ready    (w_rdy[NSTG]),
        .i_data     (w_cd[NSTG]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_mode (o_out_mode),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y)
    );

`ifndef SYNTHESIS
    // quadrant fold must hand the CORDIC a vector with x >= 0
    a_fold_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[0] |-> !w_cd[0].x[XW-1])
        else $error("CORDIC start vector has negative x");

    // with the output register empty the whole pipeline must accept
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output register empty");

    // last CORDIC stage holds its item while the window stage is stalled
    a_last_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[NSTG] && !w_rdy[NSTG]) |=> (w_vld[NSTG] && $stable(w_cd[NSTG])))
        else $error("CORDIC item changed during stall");
`endif

endmodule

>>> bench/lidar_overlap_sector_filter_top_tb.sv
module lidar_overlap_sector_filter_top_tb;
    import lidsf_pkg::*;

    localparam int  STAGES      = 16;
    localparam int  N_ITER      = (STAGES > 24) ? 24 : STAGES;
    // register stages from acceptance to o_valid
    localparam int  LAT         = N_ITER + 5;
    localparam int  HOLD_CYCLES = 200;
    localparam int  LIMIT       = 600000;

    localparam logic MODE_REF    = 1'b0;   // reference-sensor point, rear window
    localparam logic MODE_SECOND = 1'b1;   // second-sensor point, front window

    // pi/2 in the radians x 2^30 angle format
    localparam longint Z_HALF_PI = 64'sd1686629713;

    typedef struct packed {
        logic                 mode;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_scan_pt;

    // atan(2^-i) x 2^30, truncated
    longint atan_tbl [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767,
        16383,     8191,      4095,      2047,
        1023,      511,       255,       127
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CW-1:0]        cfg_data  = '0;
    logic                 cfg_ready;

    logic                 pt_valid = 1'b0;
    logic                 pt_mode  = 1'b0;
    logic signed [CW-1:0] pt_x     = '0;
    logic signed [CW-1:0] pt_y     = '0;
    logic                 pt_ready;

    logic                 kept_valid;
    logic                 out_ready = 1'b0;
    logic                 kept_mode;
    logic signed [CW-1:0] kept_x;
    logic signed [CW-1:0] kept_y;

    // Shadow copy of the register file, indexed by register number
    logic signed [CW-1:0] cfg_regs [8];

    t_scan_pt pending_pts [$];   // points waiting for the input channel
    t_scan_pt kept_q [$];        // points predicted to pass, oldest first

    int   n_pushed   = 0;
    int   n_accepted = 0;
    int   errors     = 0;
    int   cycles     = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    int   hold_seen  = 0;
    int   hold_reqs  = 0;
    logic idle_en    = 1'b1;

    lidar_overlap_sector_filter_top #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_valid    (pt_valid),
        .o_ready    (pt_ready),
        .i_mode     (pt_mode),
        .i_point_x  (pt_x),
        .i_point_y  (pt_y),
        .o_valid    (kept_valid),
        .i_ready    (out_ready),
        .o_out_mode (kept_mode),
        .o_out_x    (kept_x),
        .o_out_y    (kept_y)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int srange(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // CORDIC vectoring: bearing of (x, y) in radians x 2^30.
    // >>> on longint is an arithmetic, i.e. floor, shift.
    function automatic longint bearing_q30(input longint xi, input longint yi);
        longint x, y, z, t, xs, ys;
        int     i;
        x = xi;
        y = yi;
        z = 0;
        // fold the left half plane into the right one
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = Z_HALF_PI;
            end else begin
                x = -y;
                y = t;
                z = -Z_HALF_PI;
            end
        end
        for (i = 0; i < N_ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tbl[i];
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tbl[i];
            end
        end
        return z;
    endfunction

    function automatic bit in_sector(input t_scan_pt p);
        longint u, v, dx, dy, c, s, lo, hi, ang;
        if (p.mode == MODE_REF) begin
            // into the second sensor frame: shift, then rotate by minus yaw
            dx = longint'(p.x) - longint'(cfg_regs[REG_OFFSET_X]);
            dy = longint'(p.y) - longint'(cfg_regs[REG_OFFSET_Y]);
            c  = longint'(cfg_regs[REG_YAW_COS]);
            s  = longint'(cfg_regs[REG_YAW_SIN]);
            u  = c * dx + s * dy;
            v  = c * dy - s * dx;
            lo = longint'(cfg_regs[REG_REAR_LOW]);
            hi = longint'(cfg_regs[REG_REAR_HIGH]);
        end else begin
            u  = longint'(p.x) * 16384;
            v  = longint'(p.y) * 16384;
            lo = longint'(cfg_regs[REG_FRONT_LOW]);
            hi = longint'(cfg_regs[REG_FRONT_HIGH]);
        end
        ang = bearing_q30(u, v);
        // bounds are rad x 8192, angle is rad x 2^30
        return (ang >= lo * 131072) && (ang <= hi * 131072);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued points, with random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            pt_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (pt_valid && pt_ready) begin
                if (in_sector('{pt_mode, pt_x, pt_y}))
                    kept_q.insert(kept_q.size(), '{pt_mode, pt_x, pt_y});
                n_accepted++;
            end
            // the slot is free after this edge: gap or next point
            if (!pt_valid || pt_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pt_valid <= 1'b0;
                end else if (pending_pts.size() > 0) begin
                    pt_mode  <= pending_pts[0].mode;
                    pt_x     <= pending_pts[0].x;
                    pt_y     <= pending_pts[0].y;
                    pt_valid <= 1'b1;
                    void'(pending_pts.pop_front());
                    if (idle_en && $urandom_range(0, 2) == 0)
                        gap_left = pause_len();
                end else begin
                    pt_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen++;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = pause_len() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every kept point against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && kept_valid && out_ready) begin
            if (kept_q.size() == 0) begin
                $error("unexpected kept point: mode %0d x %0d y %0d",
                       kept_mode, kept_x, kept_y);
                errors++;
            end else begin
                if (kept_mode !== kept_q[0].mode) begin
                    $error("out_mode mismatch: expected %0d, got %0d",
                           kept_q[0].mode, kept_mode);
                    errors++;
                end
                if (kept_x !== kept_q[0].x) begin
                    $error("out_x mismatch: expected %0d, got %0d", kept_q[0].x, kept_x);
                    errors++;
                end
                if (kept_y !== kept_q[0].y) begin
                    $error("out_y mismatch: expected %0d, got %0d", kept_q[0].y, kept_y);
                    errors++;
                end
                void'(kept_q.pop_front());
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("lidar_overlap_sector_filter_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    task automatic queue_point(input t_scan_pt p);
        pending_pts.insert(pending_pts.size(), p);
        n_pushed++;
    endtask

    // Random point; a quarter land close to the origin of the window under
    // test so that bearings spread over the whole circle
    function automatic t_scan_pt rand_point();
        t_scan_pt p;
        p.mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
            if (p.mode == MODE_REF) begin
                p.x = CW'(cfg_regs[REG_OFFSET_X] + srange(-64, 64));
                p.y = CW'(cfg_regs[REG_OFFSET_Y] + srange(-64, 64));
            end else begin
                p.x = CW'(srange(-64, 64));
                p.y = CW'(srange(-64, 64));
            end
        end else begin
            p.x = CW'($urandom);
            p.y = CW'($urandom);
        end
        return p;
    endfunction

    // Wait until every point is in and every kept point is out, then let
    // dropped points still in the pipeline run off the end
    task automatic drain();
        while (n_accepted != n_pushed || kept_q.size() != 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CW-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_regs[idx] = val[CW-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cfg(input int ox, input int oy, input int c, input int s,
                            input int fl, input int fh, input int rl, input int rh);
        drain();
        write_reg(REG_OFFSET_X,   ox);
        write_reg(REG_OFFSET_Y,   oy);
        write_reg(REG_YAW_COS,    c);
        write_reg(REG_YAW_SIN,    s);
        write_reg(REG_FRONT_LOW,  fl);
        write_reg(REG_FRONT_HIGH, fh);
        write_reg(REG_REAR_LOW,   rl);
        write_reg(REG_REAR_HIGH,  rh);
    endtask

    initial begin
        // zero vector, negative x axis, corners, unit steps on the axes, full-scale +y
        int dir_x [10] = '{0, -1000, 32767, -32768, -32768, 32767, 0, 1, -1, 0};
        int dir_y [10] = '{0, 0, 32767, -32768, 32767, -32768, -1, 0, 0, 32767};
        int       k, ph, n, fl, fh, rl, rh;
        t_scan_pt p;

        cfg_regs[REG_OFFSET_X]   = 16'sd0;
        cfg_regs[REG_OFFSET_Y]   = 16'sd0;
        cfg_regs[REG_YAW_COS]    = 16'sd16384;
        cfg_regs[REG_YAW_SIN]    = 16'sd0;
        cfg_regs[REG_FRONT_LOW]  = -16'sd25736;
        cfg_regs[REG_FRONT_HIGH] = 16'sd25736;
        cfg_regs[REG_REAR_LOW]   = -16'sd25736;
        cfg_regs[REG_REAR_HIGH]  = 16'sd25736;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points under the reset configuration, both modes
        for (k = 0; k < 20; k++) begin
            p.mode = (k < 10) ? MODE_SECOND : MODE_REF;
            p.x    = CW'(dir_x[k % 10]);
            p.y    = CW'(dir_y[k % 10]);
            queue_point(p);
        end

        // Extreme offsets, yaw of 135 degrees, narrow windows
        load_cfg(-32768, 32767, -11585, 11585, -6434, 6434, 0, 12868);
        for (n = 0; n < 60; n++) queue_point(rand_point());

        // Low bound above high bound: both windows empty
        load_cfg(32767, -32768, -16384, 16384, 1000, -1000, 25736, -25736);
        for (n = 0; n < 40; n++) queue_point(rand_point());

        // Registers outside their ranges: full 16-bit yaw, bounds beyond pi
        load_cfg(12345, -23456, 32767, -32768, -32768, 32767, -32768, 32767);
        for (n = 0; n < 60; n++) queue_point(rand_point());

        // Output held off while points keep coming, so the pipeline fills
        // and the input stalls; the wide windows keep most points
        load_cfg(0, 0, 16384, 0, -25736, 25736, -25736, 25736);
        idle_en <= 1'b0;
        hold_reqs <= hold_reqs + 1;
        for (n = 0; n < 100; n++) queue_point(rand_point());

        // Random configurations; the last one uses raw 16-bit values
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                load_cfg($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end else begin
                fl = srange(-25736, 25736);
                fh = fl + srange(0, 30000);
                if (fh > 25736) fh = 25736;
                rl = srange(-25736, 25736);
                rh = rl + srange(0, 30000);
                if (rh > 25736) rh = 25736;
                load_cfg(srange(-32768, 32767), srange(-32768, 32767),
                         srange(-16384, 16384), srange(-16384, 16384), fl, fh, rl, rh);
            end
            // every other phase runs without idling on either side
            idle_en <= (ph % 2 == 0);
            for (n = 0; n < 90; n++) queue_point(rand_point());
        end

        drain();
        if (errors == 0)
            $display("lidar_overlap_sector_filter_top test passed");
        else
            $display("lidar_overlap_sector_filter_top test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/lidsf_pkg.sv
hdl/lidsf_cfg.sv
hdl/lidsf_front.sv
hdl/lidsf_cordic_stage.sv
hdl/lidsf_window.sv
hdl/lidar_overlap_sector_filter_top.sv
bench/lidar_overlap_sector_filter_top_tb.sv
